// ===== hdl/dfh_pkg.sv =====
// ----------------------------------------------------------------------------
// dfh_pkg
// Shared types, constants and code tables of the fixed-Huffman compressor.
// ----------------------------------------------------------------------------
package dfh_pkg;

	localparam int POS_W       = 32;
	localparam int BUF_AW      = 16;
	localparam int BUF_ENTRIES = 65536;
	localparam int WIN_AW      = 15;
	localparam int WIN_ENTRIES = 32768;
	localparam int HASH_AW     = 15;
	localparam int HASH_ENTRIES = 32768;
	localparam int MIN_LEN     = 3;
	localparam int MAX_LEN     = 258;
	localparam int LEN_W       = 9;
	localparam int DIST_W      = 16;
	localparam int LIM_W       = 11;
	localparam int LIMIT_RST   = 64;
	localparam int ACC_W       = 40;
	localparam int CNT_W       = 6;
	localparam int CODE_W      = 9;
	localparam int BITS_W      = 18;
	localparam int NBITS_W     = 5;
	localparam int HDR_BITS    = 3;
	localparam int EOB_NBITS   = 7;

	localparam logic REQ_DATA   = 1'b0;
	localparam logic REQ_FINISH = 1'b1;

	localparam logic [CODE_W-1:0] LIT_LO_BASE = 9'h030;
	localparam logic [CODE_W-1:0] LIT_HI_BASE = 9'h190;
	localparam logic [CODE_W-1:0] LEN_HI_BASE = 9'h0C0;
	localparam int LIT_LO_MAX   = 143;
	localparam int LIT_HI_MIN   = 144;
	localparam int LEN_SYM0     = 257;
	localparam int LEN_SYM_7MAX = 279;
	localparam int LEN_LC_7MAX  = LEN_SYM_7MAX - LEN_SYM0;

	localparam int LEN_CODES  = 29;
	localparam int DIST_CODES = 30;

	localparam logic [LEN_W-1:0] LEN_BASE [LEN_CODES] = '{
		9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
		9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
		9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258};
	localparam logic [2:0] LEN_EXTRA [LEN_CODES] = '{
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
		3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd0};
	localparam logic [DIST_W-1:0] DIST_BASE [DIST_CODES] = '{
		16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
		16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385, 16'd513,
		16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097, 16'd6145,
		16'd8193, 16'd12289, 16'd16385, 16'd24577};
	localparam logic [3:0] DIST_EXTRA [DIST_CODES] = '{
		4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
		4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
		4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13};

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_CHK, ST_DEC, ST_INS_CHK, ST_H_RD0, ST_H_RD1, ST_H_RD2,
		ST_H_HEAD, ST_WALK, ST_CMP_RD, ST_CMP_CK, ST_CMP_DONE, ST_LINK, ST_EMIT,
		ST_LIT, ST_MATCH_D, ST_DRAIN, ST_EOB, ST_FLUSH
	} state_t;

	typedef enum logic [1:0] {WS_HASH01, WS_HASH2, WS_CMP, WS_POS} win_sel_t;

	typedef enum logic [2:0] {PUT_NONE, PUT_LIT, PUT_LEN, PUT_DIST, PUT_EOB} put_sel_t;

	typedef struct packed {
		logic [BITS_W-1:0]  bits;
		logic [NBITS_W-1:0] nbits;
	} code_t;

	typedef struct packed {
		logic     append;
		logic     set_fin;
		logic     dec_init;
		logic     hsrch;
		logic     cap_b01;
		logic     cap_hidx;
		logic     ins_wr;
		logic     cand_head;
		logic     cand_link;
		logic     cmp_start;
		logic     len_inc;
		logic     best_upd;
		logic     adv_match;
		logic     adv_lit;
		logic     push;
		logic     flush;
		logic     stream_clr;
		logic     clr_wr;
		win_sel_t win;
		put_sel_t put;
	} dp_cmd_t;

	typedef struct packed {
		logic can_append;
		logic avail_full;
		logic avail_ge3;
		logic pend;
		logic ins_more;
		logic walk_ok;
		logic len_lt_lim;
		logic bytes_eq;
		logic better;
		logic len_max;
		logic best_ge3;
		logic cnt_ge8;
		logic cnt_nz;
		logic out_free;
		logic clr_done;
	} dp_stat_t;

	// bit-reverse an n-bit Huffman code so it can be packed LSB first
	function automatic logic [CODE_W-1:0] rev_code(input logic [CODE_W-1:0] code,
		input logic [3:0] n);
		logic [CODE_W-1:0] r;
		for (int i = 0; i < CODE_W; i++) r[i] = code[CODE_W-1-i];
		return r >> (4'(CODE_W) - n);
	endfunction

	function automatic code_t lit_code(input logic [7:0] b);
		code_t c;
		logic [CODE_W-1:0] sc;
		logic [3:0] sn;
		if ({1'b0, b} <= 9'(LIT_LO_MAX)) begin
			sc = LIT_LO_BASE + {1'b0, b};
			sn = 4'd8;
		end else begin
			sc = LIT_HI_BASE + {1'b0, b} - 9'(LIT_HI_MIN);
			sn = 4'd9;
		end
		c.bits  = BITS_W'(rev_code(sc, sn));
		c.nbits = NBITS_W'(sn);
		return c;
	endfunction

	function automatic code_t len_code(input logic [LEN_W-1:0] len);
		code_t c;
		logic [4:0] lc;
		logic [CODE_W-1:0] sc;
		logic [3:0] sn;
		logic [LEN_W-1:0] ext;
		lc = '0;
		for (int i = 1; i < LEN_CODES; i++) if (len >= LEN_BASE[i]) lc = 5'(i);
		if (lc <= 5'(LEN_LC_7MAX)) begin
			sc = 9'(lc) + 9'd1;
			sn = 4'd7;
		end else begin
			sc = LEN_HI_BASE + 9'(lc) - 9'(LEN_LC_7MAX + 1);
			sn = 4'd8;
		end
		ext     = len - LEN_BASE[lc];
		c.bits  = BITS_W'(rev_code(sc, sn)) | (BITS_W'(ext) << sn);
		c.nbits = NBITS_W'(sn) + NBITS_W'(LEN_EXTRA[lc]);
		return c;
	endfunction

	function automatic code_t dist_code(input logic [DIST_W-1:0] d);
		code_t c;
		logic [4:0] dc;
		logic [DIST_W-1:0] ext;
		dc = '0;
		for (int i = 1; i < DIST_CODES; i++) if (d >= DIST_BASE[i]) dc = 5'(i);
		ext     = d - DIST_BASE[dc];
		c.bits  = BITS_W'(rev_code(9'(dc), 4'd5)) | (BITS_W'(ext) << 5);
		c.nbits = NBITS_W'(5) + NBITS_W'(DIST_EXTRA[dc]);
		return c;
	endfunction

	function automatic logic [HASH_AW-1:0] hash3(input logic [7:0] b0,
		input logic [7:0] b1, input logic [7:0] b2);
		logic [17:0] h;
		h = {b0, 10'd0} ^ {5'd0, b1, 5'd0} ^ {10'd0, b2};
		return h[HASH_AW-1:0];
	endfunction

endpackage

// ===== hdl/dfh_req_if.sv =====
// ----------------------------------------------------------------------------
// dfh_req_if
// Input channel: data bytes and finish steps.
// ----------------------------------------------------------------------------
interface dfh_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] data_byte;

	modport source(output valid, req_type, data_byte, input ready);
	modport sink(input valid, req_type, data_byte, output ready);
endinterface

// ===== hdl/dfh_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dfh_rsp_if
// Output channel: compressed stream bytes.
// ----------------------------------------------------------------------------
interface dfh_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source(output valid, out_byte, last, input ready);
	modport sink(input valid, out_byte, last, output ready);
endinterface

// ===== hdl/dfh_datapath.sv =====
// ----------------------------------------------------------------------------
// dfh_datapath
// Window, hash head and chain memories, match search registers, bit packer.
// ----------------------------------------------------------------------------
module dfh_datapath import dfh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	input  logic [7:0]       data_byte,
	input  logic             cfg_we,
	input  logic [LIM_W-1:0] cfg_wdata,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [7:0]       out_byte,
	output logic             out_last
);

	logic [POS_W-1:0]   br_q, np_q, hu_q;
	logic               fin_q;
	logic [ACC_W-1:0]   acc_q, acc_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [HASH_AW-1:0] clr_q;
	logic [LIM_W-1:0]   limit_q;
	logic               out_valid_q;

	logic [LEN_W-1:0]   lim_q, best_len_q, len_q;
	logic [DIST_W-1:0]  best_dist_q;
	logic [LIM_W-1:0]   n_q;
	logic [POS_W-1:0]   cand_q;
	logic [7:0]         b0_q, b1_q;
	logic [HASH_AW-1:0] hidx_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;

	logic [7:0]         win_mem [BUF_ENTRIES];
	logic [POS_W-1:0]   head_mem [HASH_ENTRIES];
	logic [POS_W-1:0]   link_mem [WIN_ENTRIES];
	logic [7:0]         win_a_q, win_b_q;
	logic [POS_W-1:0]   head_rd_q, link_rd_q;

	logic [POS_W-1:0]   hp, cp, cur_dist, avail;
	logic [BUF_AW-1:0]  win_addr_a, win_addr_b;
	logic [HASH_AW-1:0] hidx_new, head_addr;
	logic               head_we;
	logic [POS_W-1:0]   head_wdata;
	logic [WIN_AW-1:0]  link_addr;
	code_t              put_c;

	assign hp       = cmd.hsrch ? np_q : hu_q;
	assign cp       = cand_q - POS_W'(1);
	assign cur_dist = np_q - cp;
	assign avail    = br_q - np_q;
	assign hidx_new = hash3(b0_q, b1_q, win_a_q);

	always_comb begin
		unique case (cmd.win)
			WS_HASH01: begin
				win_addr_a = hp[BUF_AW-1:0];
				win_addr_b = hp[BUF_AW-1:0] + BUF_AW'(1);
			end
			WS_HASH2: begin
				win_addr_a = hp[BUF_AW-1:0] + BUF_AW'(2);
				win_addr_b = hp[BUF_AW-1:0];
			end
			WS_CMP: begin
				win_addr_a = cp[BUF_AW-1:0] + BUF_AW'(len_q);
				win_addr_b = np_q[BUF_AW-1:0] + BUF_AW'(len_q);
			end
			WS_POS: begin
				win_addr_a = np_q[BUF_AW-1:0];
				win_addr_b = np_q[BUF_AW-1:0];
			end
			default: begin
				win_addr_a = np_q[BUF_AW-1:0];
				win_addr_b = np_q[BUF_AW-1:0];
			end
		endcase
	end

	always_comb begin
		if (cmd.clr_wr) begin
			head_addr = clr_q;
		end else if (cmd.ins_wr) begin
			head_addr = hidx_q;
		end else begin
			head_addr = hidx_new;
		end
	end
	assign head_we    = cmd.clr_wr | cmd.ins_wr;
	assign head_wdata = cmd.clr_wr ? '0 : hu_q + POS_W'(1);
	assign link_addr  = cmd.ins_wr ? hu_q[WIN_AW-1:0] : cp[WIN_AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			win_mem[br_q[BUF_AW-1:0]] <= data_byte;
		end
		win_a_q <= win_mem[win_addr_a];
		win_b_q <= win_mem[win_addr_b];
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_addr] <= head_wdata;
		end
		head_rd_q <= head_mem[head_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_wr) begin
			link_mem[link_addr] <= head_rd_q;
		end
		link_rd_q <= link_mem[link_addr];
	end

	// bit packer: append a code above the pending bits, or drop the low byte
	always_comb begin
		unique case (cmd.put)
			PUT_LIT:  put_c = lit_code(win_a_q);
			PUT_LEN:  put_c = len_code(best_len_q);
			PUT_DIST: put_c = dist_code(best_dist_q);
			PUT_EOB:  put_c = '{bits: '0, nbits: NBITS_W'(EOB_NBITS)};
			default:  put_c = '{bits: '0, nbits: '0};
		endcase
		acc_d = acc_q;
		cnt_d = cnt_q;
		if (cmd.push) begin
			acc_d = acc_q >> 8;
			cnt_d = (cnt_q > CNT_W'(8)) ? cnt_q - CNT_W'(8) : '0;
		end else if (cmd.put != PUT_NONE) begin
			acc_d = acc_q | (ACC_W'(put_c.bits) << cnt_q);
			cnt_d = cnt_q + CNT_W'(put_c.nbits);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			br_q        <= '0;
			np_q        <= '0;
			hu_q        <= '0;
			fin_q       <= 1'b0;
			acc_q       <= ACC_W'(HDR_BITS);
			cnt_q       <= CNT_W'(HDR_BITS);
			clr_q       <= '0;
			limit_q     <= LIM_W'(LIMIT_RST);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.stream_clr) begin
				br_q  <= '0;
				np_q  <= '0;
				hu_q  <= '0;
				fin_q <= 1'b0;
				acc_q <= ACC_W'(HDR_BITS);
				cnt_q <= CNT_W'(HDR_BITS);
				clr_q <= '0;
			end else begin
				acc_q <= acc_d;
				cnt_q <= cnt_d;
				if (cmd.append)    br_q  <= br_q + POS_W'(1);
				if (cmd.set_fin)   fin_q <= 1'b1;
				if (cmd.ins_wr)    hu_q  <= hu_q + POS_W'(1);
				if (cmd.adv_match) np_q  <= np_q + POS_W'(best_len_q);
				if (cmd.adv_lit)   np_q  <= np_q + POS_W'(1);
				if (cmd.clr_wr)    clr_q <= clr_q + HASH_AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dec_init) begin
			best_len_q  <= '0;
			best_dist_q <= '0;
			n_q         <= '0;
			lim_q       <= (avail >= POS_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : avail[LEN_W-1:0];
		end
		if (cmd.cap_b01) begin
			b0_q <= win_a_q;
			b1_q <= win_b_q;
		end
		if (cmd.cap_hidx)  hidx_q <= hidx_new;
		if (cmd.cand_head) cand_q <= head_rd_q;
		if (cmd.cand_link) begin
			cand_q <= link_rd_q;
			n_q    <= n_q + LIM_W'(1);
		end
		if (cmd.cmp_start) len_q <= '0;
		if (cmd.len_inc)   len_q <= len_q + LEN_W'(1);
		if (cmd.best_upd && stat.better) begin
			best_len_q  <= len_q;
			best_dist_q <= cur_dist[DIST_W-1:0];
		end
		if (cmd.push) begin
			out_byte_q <= acc_q[7:0];
			out_last_q <= cmd.flush && (cnt_q <= CNT_W'(8));
		end
	end

	always_comb begin
		stat.can_append = !fin_q && (br_q != '1);
		stat.avail_full = avail >= POS_W'(MAX_LEN);
		stat.avail_ge3  = avail >= POS_W'(MIN_LEN);
		stat.pend       = np_q < br_q;
		stat.ins_more   = (hu_q < np_q) &&
			(({1'b0, hu_q} + (POS_W+1)'(MIN_LEN)) <= {1'b0, br_q});
		stat.walk_ok    = (cand_q != '0) && (n_q < limit_q) && (cp < np_q) &&
			(cur_dist <= POS_W'(WIN_ENTRIES));
		stat.len_lt_lim = len_q < lim_q;
		stat.bytes_eq   = win_a_q == win_b_q;
		stat.better     = len_q > best_len_q;
		stat.len_max    = len_q >= LEN_W'(MAX_LEN);
		stat.best_ge3   = best_len_q >= LEN_W'(MIN_LEN);
		stat.cnt_ge8    = cnt_q >= CNT_W'(8);
		stat.cnt_nz     = cnt_q != '0;
		stat.out_free   = !out_valid_q || out_ready;
		stat.clr_done   = clr_q == '1;
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

// ===== hdl/dfh_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfh_ctrl
// Sequencer: append, hash insertion, chain walk, code emission, flush, clear.
// ----------------------------------------------------------------------------
module dfh_ctrl import dfh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_type,
	output logic     req_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;
	logic   hmode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			hmode_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INS_CHK) begin
				hmode_q <= !stat.ins_more;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:    if (stat.clr_done) state_d = ST_IDLE;
			ST_IDLE: begin
				if (req_valid) begin
					if (req_type == REQ_DATA) begin
						state_d = stat.can_append ? ST_CHK : ST_IDLE;
					end else begin
						state_d = stat.pend ? ST_DEC : ST_EOB;
					end
				end
			end
			ST_CHK:      state_d = stat.avail_full ? ST_DEC : ST_IDLE;
			ST_DEC:      state_d = stat.avail_ge3 ? ST_INS_CHK : ST_EMIT;
			ST_INS_CHK:  state_d = ST_H_RD0;
			ST_H_RD0:    state_d = ST_H_RD1;
			ST_H_RD1:    state_d = ST_H_RD2;
			ST_H_RD2:    state_d = ST_H_HEAD;
			ST_H_HEAD:   state_d = hmode_q ? ST_WALK : ST_INS_CHK;
			ST_WALK:     state_d = stat.walk_ok ? ST_CMP_RD : ST_EMIT;
			ST_CMP_RD:   state_d = stat.len_lt_lim ? ST_CMP_CK : ST_CMP_DONE;
			ST_CMP_CK:   state_d = stat.bytes_eq ? ST_CMP_RD : ST_CMP_DONE;
			ST_CMP_DONE: state_d = (stat.better && stat.len_max) ? ST_EMIT : ST_LINK;
			ST_LINK:     state_d = ST_WALK;
			ST_EMIT:     state_d = stat.best_ge3 ? ST_MATCH_D : ST_LIT;
			ST_LIT:      state_d = ST_DRAIN;
			ST_MATCH_D:  state_d = ST_DRAIN;
			ST_DRAIN:    if (!stat.cnt_ge8) state_d = ST_IDLE;
			ST_EOB:      state_d = ST_FLUSH;
			ST_FLUSH:    if (!stat.cnt_nz) state_d = ST_CLEAR;
			default:     state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.hsrch = hmode_q;
		cmd.win   = WS_CMP;
		cmd.put   = PUT_NONE;
		req_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_type == REQ_DATA) begin
						cmd.append = stat.can_append;
					end else begin
						cmd.set_fin = 1'b1;
					end
				end
			end
			ST_DEC:     cmd.dec_init = 1'b1;
			ST_INS_CHK: cmd.hsrch = !stat.ins_more;
			ST_H_RD0:   cmd.win = WS_HASH01;
			ST_H_RD1: begin
				cmd.cap_b01 = 1'b1;
				cmd.win     = WS_HASH2;
			end
			ST_H_RD2:   cmd.cap_hidx = 1'b1;
			ST_H_HEAD: begin
				cmd.ins_wr    = !hmode_q;
				cmd.cand_head = hmode_q;
			end
			ST_WALK:     cmd.cmp_start = stat.walk_ok;
			ST_CMP_RD:   cmd.win = WS_CMP;
			ST_CMP_CK:   cmd.len_inc = stat.bytes_eq;
			ST_CMP_DONE: cmd.best_upd = 1'b1;
			ST_LINK:     cmd.cand_link = 1'b1;
			ST_EMIT: begin
				cmd.win = WS_POS;
				if (stat.best_ge3) begin
					cmd.put       = PUT_LEN;
					cmd.adv_match = 1'b1;
				end
			end
			ST_LIT: begin
				cmd.put     = PUT_LIT;
				cmd.adv_lit = 1'b1;
			end
			ST_MATCH_D: cmd.put = PUT_DIST;
			ST_DRAIN:   cmd.push = stat.cnt_ge8 && stat.out_free;
			ST_EOB:     cmd.put = PUT_EOB;
			ST_FLUSH: begin
				cmd.flush      = 1'b1;
				cmd.push       = stat.cnt_nz && stat.out_free;
				cmd.stream_clr = !stat.cnt_nz;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== hdl/deflate_fixed_huffman_compressor_unit.sv =====
// ----------------------------------------------------------------------------
// deflate_fixed_huffman_compressor_unit
// Greedy LZ77 over a hash chain, coded as one final fixed-Huffman block.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | beat payload
//  --------+-----+------------------+--------------------------------------
//  req     | in  | valid / ready    | req_type (0 data, 1 finish), data_byte
//  rsp     | out | valid / ready    | out_byte (LSB-first bits), last
//  cfg     | in  | cfg_we           | cfg_wdata = chain_limit (11 bits)
//
//  A data beat only appends a byte unless it completes a 258-byte lookahead;
//  then one position is decided: each pending hash insertion (normally one),
//  hashing the position, and a byte-by-byte compare per chain candidate,
//  bounded by chain_limit. Coding then emits the codes and drains whole bytes.
//  Each window access goes through the window memory's two read ports, which
//  sets the per-byte compare cost.
//  After reset and after each end of stream the hash heads are cleared,
//  one entry per cycle, all 32768 of them, with req.ready low.
//  A stalled rsp holds the sequencer at its next output beat; one beat may
//  wait in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module deflate_fixed_huffman_compressor_unit import dfh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	dfh_req_if.sink          req,
	dfh_rsp_if.source        rsp,
	input  logic             cfg_we,
	input  logic [LIM_W-1:0] cfg_wdata
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     req_ready;

	// sequencer: owns the request handshake and steps the datapath
	dfh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// memories, search state and the bit packer with its output register
	dfh_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.data_byte (req.data_byte),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_byte  (rsp.out_byte),
		.out_last  (rsp.last)
	);

	assign req.ready = req_ready;

	// idle only with less than a whole byte pending in the packer
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !stat.cnt_ge8)
		else $error("whole byte left in packer while idle");

	// never overwrite a beat the sink has not taken
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> stat.out_free)
		else $error("output beat overwritten");

	// a byte enters the window only on an accepted data beat
	a_append_acc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> (req.valid && req.ready && req.req_type == REQ_DATA))
		else $error("window write without accepted data beat");

endmodule
